// File: src/shbe_pkg.sv
package shbe_pkg;

   localparam int MAX_DEGREE_DEF    = 8;
   localparam int ANGLE_BITS_DEF    = 16;
   localparam int OUT_FRAC_BITS_DEF = 23;

   localparam int DEG_W  = 4;
   localparam int TAB_N  = 10;
   localparam int TAB_IW = 7;
   localparam int QF     = 28;

   localparam logic [DEG_W-1:0] LIMIT_RESET = 4'd8;
   localparam logic [4:0]       TRIG_LAST   = 5'd21;
   localparam logic [31:0]      PI_Q29      = 32'h6487_ED51;
   localparam logic [31:0]      ONE_Q30     = 32'h4000_0000;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ANG_EL,
      OP_ANG_AZ,
      OP_T_R,
      OP_T_T2,
      OP_H_MUL,
      OP_H_DIV,
      OP_S_FIN,
      OP_C_FIN,
      OP_SET_XU,
      OP_STORE_AZ,
      OP_L_0,
      OP_L_T1,
      OP_L_AT,
      OP_L_BO,
      OP_L_DU,
      OP_L_DC,
      OP_O_C,
      OP_O_S,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic             valid;
      op_type           op;
      logic [3:0]       kidx;
      logic [DEG_W-1:0] n;
      logic [DEG_W-1:0] m;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   function automatic op_type trig_op(input logic [4:0] step);
      op_type op;
      if (step == 5'd0) begin
         op = OP_T_R;
      end else if (step == 5'd1) begin
         op = OP_T_T2;
      end else if (step <= 5'd9) begin
         op = step[0] ? OP_H_DIV : OP_H_MUL;
      end else if (step == 5'd10) begin
         op = OP_S_FIN;
      end else if (step <= 5'd20) begin
         op = step[0] ? OP_H_MUL : OP_H_DIV;
      end else begin
         op = OP_C_FIN;
      end
      return op;
   endfunction

   function automatic logic [3:0] trig_k(input logic [4:0] step);
      logic [4:0] d;
      d = 5'd0;
      if (step >= 5'd2 && step <= 5'd9) begin
         d = (step - 5'd2) >> 1;
      end else if (step >= 5'd11 && step <= 5'd20) begin
         d = 5'd4 + ((step - 5'd11) >> 1);
      end
      return d[3:0];
   endfunction

   function automatic logic [6:0] k_val(input logic [3:0] idx);
      logic [6:0] k;
      unique case (idx)
         4'd0:    k = 7'd72;
         4'd1:    k = 7'd42;
         4'd2:    k = 7'd20;
         4'd3:    k = 7'd6;
         4'd4:    k = 7'd90;
         4'd5:    k = 7'd56;
         4'd6:    k = 7'd30;
         4'd7:    k = 7'd12;
         default: k = 7'd2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] k_rcp(input logic [3:0] idx);
      logic [63:0] r;
      unique case (idx)
         4'd0:    r = 64'h1_0000_0000 / 64'd72;
         4'd1:    r = 64'h1_0000_0000 / 64'd42;
         4'd2:    r = 64'h1_0000_0000 / 64'd20;
         4'd3:    r = 64'h1_0000_0000 / 64'd6;
         4'd4:    r = 64'h1_0000_0000 / 64'd90;
         4'd5:    r = 64'h1_0000_0000 / 64'd56;
         4'd6:    r = 64'h1_0000_0000 / 64'd30;
         4'd7:    r = 64'h1_0000_0000 / 64'd12;
         default: r = 64'h1_0000_0000 / 64'd2;
      endcase
      return r[31:0];
   endfunction

   // floor(2^26 * sqrt(num / den)) by shift-subtract division and a digit-wise root.
   function automatic logic [31:0] coef_f(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] dvd;
      logic [63:0] r;
      logic [63:0] q;
      logic [63:0] y;
      logic [63:0] res;
      logic [63:0] b;
      if (den == 64'd0) begin
         return 32'd0;
      end
      dvd = num << 52;
      r   = 64'd0;
      q   = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], dvd[i]};
         q = q << 1;
         if (r >= den) begin
            r    = r - den;
            q[0] = 1'b1;
         end
      end
      y   = q;
      res = 64'd0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > y) begin
            b = b >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (y >= res + b) begin
               y   = y - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
      end
      return res[31:0];
   endfunction

   function automatic logic [TAB_N*TAB_N*32-1:0] build_tab(input int kind);
      logic [TAB_N*TAB_N*32-1:0] tab;
      logic [31:0]               c;
      tab = '0;
      for (int n = 0; n < TAB_N; n++) begin
         for (int m = 0; m < TAB_N; m++) begin
            c = 32'd0;
            if (kind == 0 && m < n) begin
               c = coef_f(64'(4 * n * n - 1), 64'(n * n - m * m));
            end else if (kind == 1 && n >= 2 && m + 2 <= n) begin
               c = coef_f(64'((2 * n + 1) * (n + m - 1) * (n - m - 1)),
                          64'((n * n - m * m) * (2 * n - 3)));
            end else if (kind == 2 && m == 0 && n == 1) begin
               c = coef_f(64'd3, 64'd1);
            end else if (kind == 2 && m == 0 && n >= 2) begin
               c = coef_f(64'(2 * n + 1), 64'(2 * n));
            end
            tab[(n * TAB_N + m) * 32 +: 32] = c;
         end
      end
      return tab;
   endfunction

   localparam logic [TAB_N*TAB_N*32-1:0] A_TAB = build_tab(0);
   localparam logic [TAB_N*TAB_N*32-1:0] B_TAB = build_tab(1);
   localparam logic [TAB_N*TAB_N*32-1:0] D_TAB = build_tab(2);

endpackage

// File: src/shbe_ctrl.sv
module shbe_ctrl #(
   parameter int MAX_DEGREE = shbe_pkg::MAX_DEGREE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         csr_we,
   input  logic [shbe_pkg::DEG_W-1:0]   csr_wdata,
   output shbe_pkg::cmd_type            cmd,
   input  shbe_pkg::stat_type           status
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ANG   = 7'b0000010,
      ST_TRIG  = 7'b0000100,
      ST_SAVE  = 7'b0001000,
      ST_ANGAZ = 7'b0010000,
      ST_LEG   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   localparam logic [shbe_pkg::DEG_W-1:0] MAXD = shbe_pkg::DEG_W'(MAX_DEGREE);

   state_type                     state_ff, state_in;
   logic                          ph_ff, ph_in;
   logic [4:0]                    sub_ff, sub_in;
   logic [shbe_pkg::DEG_W-1:0]    n_ff, n_in;
   logic [shbe_pkg::DEG_W-1:0]    m_ff, m_in;
   logic [shbe_pkg::DEG_W-1:0]    lim_ff, lim_in;
   logic [shbe_pkg::DEG_W-1:0]    limit_ff;
   logic                          azm_ff, azm_in;
   logic [2:0]                    base;
   shbe_pkg::op_type              leg_op;
   logic [shbe_pkg::DEG_W-1:0]    clamp;

   assign req_tready = (state_ff == ST_IDLE) && !ph_ff;

   always_comb begin
      if (limit_ff == '0) begin
         clamp = shbe_pkg::DEG_W'(1);
      end else if (limit_ff > MAXD) begin
         clamp = MAXD;
      end else begin
         clamp = limit_ff;
      end
   end

   always_comb begin
      base = (n_ff == '0) ? 3'd1 : ((m_ff == n_ff) ? 3'd2 : 3'd3);
      if (sub_ff < 5'(base)) begin
         if (n_ff == '0) begin
            leg_op = shbe_pkg::OP_L_0;
         end else if (m_ff == n_ff) begin
            leg_op = (sub_ff == 5'd0) ? shbe_pkg::OP_L_DU : shbe_pkg::OP_L_DC;
         end else if (sub_ff == 5'd0) begin
            leg_op = shbe_pkg::OP_L_T1;
         end else if (sub_ff == 5'd1) begin
            leg_op = shbe_pkg::OP_L_AT;
         end else begin
            leg_op = shbe_pkg::OP_L_BO;
         end
      end else if (sub_ff == 5'(base)) begin
         leg_op = shbe_pkg::OP_O_C;
      end else begin
         leg_op = shbe_pkg::OP_O_S;
      end
   end

   always_comb begin
      state_in = state_ff;
      ph_in    = 1'b0;
      sub_in   = sub_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      lim_in   = lim_ff;
      azm_in   = azm_ff;
      cmd      = '0;
      cmd.op   = shbe_pkg::OP_NONE;
      cmd.n    = n_ff;
      cmd.m    = m_ff;
      if (!ph_ff) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  cmd.valid = 1'b1;
                  cmd.op    = shbe_pkg::OP_LOAD;
                  lim_in    = clamp;
                  state_in  = ST_ANG;
               end
            end
            ST_ANG: begin
               cmd.valid = 1'b1;
               cmd.op    = shbe_pkg::OP_ANG_EL;
               azm_in    = 1'b0;
               sub_in    = 5'd0;
               state_in  = ST_TRIG;
            end
            ST_TRIG: begin
               cmd.valid = 1'b1;
               cmd.op    = shbe_pkg::trig_op(sub_ff);
               cmd.kidx  = shbe_pkg::trig_k(sub_ff);
               if (sub_ff == shbe_pkg::TRIG_LAST) begin
                  state_in = ST_SAVE;
               end else begin
                  sub_in = sub_ff + 5'd1;
               end
            end
            ST_SAVE: begin
               cmd.valid = 1'b1;
               if (!azm_ff) begin
                  cmd.op   = shbe_pkg::OP_SET_XU;
                  azm_in   = 1'b1;
                  m_in     = '0;
                  state_in = ST_ANGAZ;
               end else begin
                  cmd.op = shbe_pkg::OP_STORE_AZ;
                  if (m_ff == lim_ff) begin
                     n_in     = '0;
                     m_in     = '0;
                     sub_in   = 5'd0;
                     state_in = ST_LEG;
                  end else begin
                     m_in     = m_ff + shbe_pkg::DEG_W'(1);
                     state_in = ST_ANGAZ;
                  end
               end
            end
            ST_ANGAZ: begin
               cmd.valid = 1'b1;
               cmd.op    = shbe_pkg::OP_ANG_AZ;
               sub_in    = 5'd0;
               state_in  = ST_TRIG;
            end
            ST_LEG: begin
               cmd.valid = 1'b1;
               cmd.op    = leg_op;
               if (leg_op == shbe_pkg::OP_O_S) begin
                  sub_in   = 5'd0;
                  state_in = ST_EMIT;
               end else begin
                  sub_in = sub_ff + 5'd1;
               end
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  cmd.valid = 1'b1;
                  cmd.op    = shbe_pkg::OP_EMIT;
                  cmd.last  = (n_ff == lim_ff) && (m_ff == n_ff);
                  if (m_ff == n_ff) begin
                     if (n_ff == lim_ff) begin
                        state_in = ST_IDLE;
                     end else begin
                        n_in     = n_ff + shbe_pkg::DEG_W'(1);
                        m_in     = '0;
                        state_in = ST_LEG;
                     end
                  end else begin
                     m_in     = m_ff + shbe_pkg::DEG_W'(1);
                     state_in = ST_LEG;
                  end
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
         ph_in = cmd.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= 1'b0;
         sub_ff   <= 5'd0;
         n_ff     <= '0;
         m_ff     <= '0;
         lim_ff   <= shbe_pkg::DEG_W'(1);
         azm_ff   <= 1'b0;
         limit_ff <= shbe_pkg::LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         sub_ff   <= sub_in;
         n_ff     <= n_in;
         m_ff     <= m_in;
         lim_ff   <= lim_in;
         azm_ff   <= azm_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

endmodule

// File: src/shbe_dp.sv
module shbe_dp #(
   parameter int MAX_DEGREE    = shbe_pkg::MAX_DEGREE_DEF,
   parameter int ANGLE_BITS    = shbe_pkg::ANGLE_BITS_DEF,
   parameter int OUT_FRAC_BITS = shbe_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  shbe_pkg::cmd_type    cmd,
   output shbe_pkg::stat_type   status,
   input  logic [31:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int DEPTH = MAX_DEGREE + 1;
   localparam int IW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int OSH   = 2 * shbe_pkg::QF - OUT_FRAC_BITS;
   localparam int ASH   = 32 - ANGLE_BITS;
   localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
   localparam logic signed [69:0] H29  = 70'sd1 <<< 29;
   localparam logic signed [69:0] H27  = 70'sd1 <<< 27;
   localparam logic signed [69:0] H25  = 70'sd1 <<< 25;
   localparam logic signed [69:0] HO   = 70'sd1 <<< (OSH - 1);
   localparam logic signed [69:0] PLIM = (70'sd1 <<< 33) - 70'sd1;
   localparam logic signed [69:0] S32H = 70'sd2147483647;
   localparam logic signed [69:0] S32L = -70'sd2147483648;

   logic [31:0]         az32_ff, el32_ff, azacc_ff, ang_ff;
   logic [31:0]         t_ff, t2_ff, w_ff, v_ff, s_ff;
   logic signed [29:0]  sn_ff, cs_ff, x_ff, u_ff;
   logic signed [29:0]  csa_ff [DEPTH];
   logic signed [29:0]  sna_ff [DEPTH];
   logic signed [34:0]  prev1_ff [DEPTH];
   logic signed [34:0]  prev2_ff [DEPTH];
   logic signed [34:0]  cur_ff [DEPTH];
   logic signed [35:0]  t1_ff;
   logic signed [44:0]  acc_ff;
   logic signed [34:0]  p_ff;
   logic signed [31:0]  cterm_ff, sterm_ff;
   logic signed [69:0]  prod_ff;
   shbe_pkg::cmd_type   cmd_ff;
   logic                rsp_valid_ff;
   logic [71:0]         rsp_data_ff;
   logic                rsp_last_ff;

   logic signed [35:0]  mul_a;
   logic signed [33:0]  mul_b;
   logic [2:0]          oct;
   logic [29:0]         red;
   logic [IW-1:0]       mi, nmi, wmi;
   logic [shbe_pkg::DEG_W-1:0] nm1;
   logic [shbe_pkg::TAB_IW-1:0] tidx, didx;
   logic                older_ok;
   logic [31:0]         ang_in_az, ang_in_el;
   logic [69:0]         rq30;
   logic signed [69:0]  r28, r26, ro, bdiff;
   logic [31:0]         q0;
   logic [39:0]         rem;
   logic [6:0]          kv;
   logic [31:0]         w_div;
   logic [31:0]         s_sum;
   logic [31:0]         c_sum;
   logic signed [29:0]  sp, cp, sn_map, cs_map;

   function automatic logic signed [34:0] sat_p(input logic signed [69:0] v);
      logic signed [69:0] r;
      r = v;
      if (v > PLIM) begin
         r = PLIM;
      end else if (v < -PLIM) begin
         r = -PLIM;
      end
      return r[34:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
      logic signed [69:0] r;
      r = v;
      if (v > S32H) begin
         r = S32H;
      end else if (v < S32L) begin
         r = S32L;
      end
      return r[31:0];
   endfunction

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tlast       = rsp_last_ff;

   assign ang_in_az = (({16'd0, req_tdata[15:0]} & AMASK) << ASH);
   assign ang_in_el = (({16'd0, req_tdata[31:16]} & AMASK) << ASH);

   assign oct  = ang_ff[31:29];
   assign red  = oct[0] ? (30'h2000_0000 - {1'b0, ang_ff[28:0]}) : {1'b0, ang_ff[28:0]};
   assign mi   = cmd.m[IW-1:0];
   assign nm1  = cmd.n - shbe_pkg::DEG_W'(1);
   assign nmi  = nm1[IW-1:0];
   assign wmi  = cmd_ff.m[IW-1:0];
   assign tidx = shbe_pkg::TAB_IW'(cmd.n) * shbe_pkg::TAB_IW'(shbe_pkg::TAB_N)
               + shbe_pkg::TAB_IW'(cmd.m);
   assign didx = shbe_pkg::TAB_IW'(cmd.n) * shbe_pkg::TAB_IW'(shbe_pkg::TAB_N);
   assign older_ok = ({1'b0, cmd.m} + 5'd2) <= {1'b0, cmd.n};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         shbe_pkg::OP_T_R: begin
            mul_a = $signed({6'd0, red});
            mul_b = $signed({2'd0, shbe_pkg::PI_Q29});
         end
         shbe_pkg::OP_T_T2: begin
            mul_a = $signed({4'd0, t_ff});
            mul_b = $signed({2'd0, t_ff});
         end
         shbe_pkg::OP_H_MUL: begin
            mul_a = $signed({4'd0, t2_ff});
            mul_b = $signed({2'd0, w_ff});
         end
         shbe_pkg::OP_H_DIV: begin
            mul_a = $signed({4'd0, v_ff});
            mul_b = $signed({2'd0, shbe_pkg::k_rcp(cmd.kidx)});
         end
         shbe_pkg::OP_S_FIN: begin
            mul_a = $signed({4'd0, t_ff});
            mul_b = $signed({2'd0, w_ff});
         end
         shbe_pkg::OP_L_T1: begin
            mul_a = 36'(prev1_ff[mi]);
            mul_b = 34'(x_ff);
         end
         shbe_pkg::OP_L_AT: begin
            mul_a = t1_ff;
            mul_b = $signed({2'd0, shbe_pkg::A_TAB[tidx*32 +: 32]});
         end
         shbe_pkg::OP_L_BO: begin
            mul_a = older_ok ? 36'(prev2_ff[mi]) : 36'sd0;
            mul_b = $signed({2'd0, shbe_pkg::B_TAB[tidx*32 +: 32]});
         end
         shbe_pkg::OP_L_DU: begin
            mul_a = 36'(prev1_ff[nmi]);
            mul_b = 34'(u_ff);
         end
         shbe_pkg::OP_L_DC: begin
            mul_a = t1_ff;
            mul_b = $signed({2'd0, shbe_pkg::D_TAB[didx*32 +: 32]});
         end
         shbe_pkg::OP_O_C: begin
            mul_a = 36'(p_ff);
            mul_b = 34'(csa_ff[mi]);
         end
         shbe_pkg::OP_O_S: begin
            mul_a = 36'(p_ff);
            mul_b = 34'(sna_ff[mi]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      rq30  = 70'(prod_ff + H29);
      r28   = (prod_ff + H27) >>> 28;
      r26   = (prod_ff + H25) >>> 26;
      ro    = (prod_ff + HO) >>> OSH;
      bdiff = 70'(acc_ff) - r26;
      kv    = shbe_pkg::k_val(cmd_ff.kidx);
      q0    = prod_ff[63:32];
      rem   = {8'd0, v_ff} - ({8'd0, q0} * 40'(kv));
      w_div = shbe_pkg::ONE_Q30 - (q0 + 32'(rem >= 40'(kv)));
      s_sum = prod_ff[61:30] + 32'd2;
      c_sum = w_ff + 32'd2;
      sp    = $signed({1'b0, s_ff[28:0]});
      cp    = $signed({1'b0, c_sum[30:2]});
      unique case (oct)
         3'd0: begin sn_map = sp;  cs_map = cp;  end
         3'd1: begin sn_map = cp;  cs_map = sp;  end
         3'd2: begin sn_map = cp;  cs_map = -sp; end
         3'd3: begin sn_map = sp;  cs_map = -cp; end
         3'd4: begin sn_map = -sp; cs_map = -cp; end
         3'd5: begin sn_map = -cp; cs_map = -sp; end
         3'd6: begin sn_map = -cp; cs_map = sp;  end
         default: begin sn_map = -sp; cs_map = cp; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff <= cmd;
         if (cmd.valid && cmd.op == shbe_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.valid && cmd.op == shbe_pkg::OP_LOAD) begin
         az32_ff <= ang_in_az;
         el32_ff <= ang_in_el;
      end
      if (cmd.valid && cmd.op == shbe_pkg::OP_EMIT) begin
         rsp_data_ff <= {sterm_ff, cterm_ff, cmd.m, cmd.n};
         rsp_last_ff <= cmd.last;
         if (cmd.m == cmd.n) begin
            for (int i = 0; i < DEPTH; i++) begin
               prev2_ff[i] <= prev1_ff[i];
               prev1_ff[i] <= cur_ff[i];
            end
         end
      end
      if (cmd_ff.valid) begin
         unique case (cmd_ff.op)
            shbe_pkg::OP_ANG_EL: begin
               ang_ff   <= el32_ff << 1;
               azacc_ff <= 32'd0;
            end
            shbe_pkg::OP_ANG_AZ: begin
               ang_ff   <= azacc_ff;
               azacc_ff <= azacc_ff + az32_ff;
            end
            shbe_pkg::OP_T_R: begin
               t_ff <= rq30[61:30];
            end
            shbe_pkg::OP_T_T2: begin
               t2_ff <= rq30[61:30];
               w_ff  <= shbe_pkg::ONE_Q30;
            end
            shbe_pkg::OP_H_MUL: begin
               v_ff <= prod_ff[61:30];
            end
            shbe_pkg::OP_H_DIV: begin
               w_ff <= w_div;
            end
            shbe_pkg::OP_S_FIN: begin
               s_ff <= s_sum >> 2;
               w_ff <= shbe_pkg::ONE_Q30;
            end
            shbe_pkg::OP_C_FIN: begin
               sn_ff <= sn_map;
               cs_ff <= cs_map;
            end
            shbe_pkg::OP_SET_XU: begin
               x_ff <= -cs_ff;
               u_ff <= (sn_ff < 0) ? -sn_ff : sn_ff;
            end
            shbe_pkg::OP_STORE_AZ: begin
               csa_ff[wmi] <= cs_ff;
               sna_ff[wmi] <= sn_ff;
            end
            shbe_pkg::OP_L_0: begin
               p_ff        <= 35'sd1 <<< shbe_pkg::QF;
               cur_ff[wmi] <= 35'sd1 <<< shbe_pkg::QF;
            end
            shbe_pkg::OP_L_T1, shbe_pkg::OP_L_DU: begin
               t1_ff <= r28[35:0];
            end
            shbe_pkg::OP_L_AT: begin
               acc_ff <= r26[44:0];
            end
            shbe_pkg::OP_L_BO: begin
               p_ff        <= sat_p(bdiff);
               cur_ff[wmi] <= sat_p(bdiff);
            end
            shbe_pkg::OP_L_DC: begin
               p_ff        <= sat_p(r26);
               cur_ff[wmi] <= sat_p(r26);
            end
            shbe_pkg::OP_O_C: begin
               cterm_ff <= sat32(ro);
            end
            shbe_pkg::OP_O_S: begin
               sterm_ff <= (cmd_ff.m == '0) ? 32'sd0 : sat32(ro);
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: src/spherical_harmonic_basis_eval.sv
// Spherical harmonic basis evaluator.
// A request carries an azimuth and an elevation as binary angles. For every
// degree n up to the configured limit L and every order m up to n, in row
// order, one response is produced with n, m and the normalised Legendre value
// times cos(m*az) and sin(m*az) in signed fixed point; tlast marks the final
// response of a request. The degree limit is written through csr_we and
// csr_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce; it resets to 8. All arithmetic runs on one
// shared multiplier; each product is registered and written back before the
// next command is issued. A sine/cosine evaluation is done once for the
// elevation and once for each order 0..L; each term then takes its Legendre
// recurrence steps, a cosine and a sine product and an emit step.
// A new request is taken only once the previous one has issued its last
// response. A response waits in an output register while the receiver
// stalls; computation of the next term carries on and halts only when the
// next response is ready and the register is still occupied.
// Reset returns the controller to idle, drops any pending response and sets
// the degree limit to 8.
module spherical_harmonic_basis_eval #(
   parameter int MAX_DEGREE    = shbe_pkg::MAX_DEGREE_DEF,
   parameter int ANGLE_BITS    = shbe_pkg::ANGLE_BITS_DEF,
   parameter int OUT_FRAC_BITS = shbe_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,  // azimuth, elevation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [71:0]                 rsp_tdata,  // degree, order, cosine_term, sine_term
   output logic                        rsp_tlast,
   input  logic                        csr_we,
   input  logic [shbe_pkg::DEG_W-1:0]  csr_wdata
);

   shbe_pkg::cmd_type  cmd;
   shbe_pkg::stat_type status;

   shbe_ctrl #(
      .MAX_DEGREE(MAX_DEGREE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

   shbe_dp #(
      .MAX_DEGREE    (MAX_DEGREE),
      .ANGLE_BITS    (ANGLE_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
